[rtl/cring_pkg.sv]
// Shared types, field widths and command codes for the circular ring list engine.
package cring_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int TAG_BITS_DEF = 32;

    localparam int KIND_W    = 2;
    localparam int TAG_IN_W  = 32;
    localparam int STEPS_W   = 16;
    localparam int TAG_OUT_W = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ROLL   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [TAG_IN_W-1:0] tag_in;
        logic                forward;
        logic [STEPS_W-1:0]  steps;
    } in_item_t;

    typedef struct packed {
        logic [TAG_OUT_W-1:0] tag_out;
        logic [STATUS_W-1:0]  status;
        logic [COUNT_W-1:0]   count;
    } out_item_t;

endpackage

[rtl/circular_ring_list_engine.sv]
// Top level of the circular ring list engine: command sequencer, link memories and free stack.
// The ring holds up to CAPACITY tags in a doubly linked list kept in block RAMs, with a cursor.
// An insert goes through a link state and a finish state, a remove through a finish state;
// errors and the unused command code go to the result state. A roll on a non-empty ring first
// reduces steps modulo the entry count in cring_rem, then one link-memory read per move.
// A finished result sits in an output register, and s_ready returns as soon as the sequencer
// is back in its idle state, even while that result has not yet been taken.
module circular_ring_list_engine #(
    parameter int CAPACITY = cring_pkg::CAPACITY_DEF,
    parameter int TAG_BITS = cring_pkg::TAG_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  cring_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cring_pkg::out_item_t m_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int TAG_WIDE = (TAG_BITS > cring_pkg::TAG_OUT_W) ? TAG_BITS : cring_pkg::TAG_OUT_W;
    localparam int CNT_WIDE = (CW > cring_pkg::COUNT_W) ? CW : cring_pkg::COUNT_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_INS_LINK  = 7'b0000010,
        ST_INS_FIN   = 7'b0000100,
        ST_REM_FIN   = 7'b0001000,
        ST_ROLL_MOD  = 7'b0010000,
        ST_ROLL_WALK = 7'b0100000,
        ST_RESULT    = 7'b1000000
    } state_t;

    state_t                         state_reg, state_next;
    logic [AW-1:0]                  cursor_reg, cursor_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [CW-1:0]                  hw_reg, hw_next;
    logic [TAG_BITS-1:0]            tag_reg, tag_next;
    logic                           fresh_reg, fresh_next;
    logic [AW-1:0]                  slot_reg, slot_next;
    logic [AW-1:0]                  before_reg, before_next;
    logic                           fwd_reg, fwd_next;
    logic [CW-1:0]                  left_reg, left_next;
    logic [cring_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                           m_valid_reg, m_valid_next;
    cring_pkg::out_item_t           m_data_reg, m_data_next;

    logic                 tag_we, tag_re;
    logic [AW-1:0]        tag_wa, tag_ra;
    logic [TAG_BITS-1:0]  tag_rd;
    logic                 next_we, next_re;
    logic [AW-1:0]        next_wa, next_wd, next_ra, next_rd;
    logic                 prev_we, prev_re;
    logic [AW-1:0]        prev_wa, prev_wd, prev_ra, prev_rd;
    logic                 free_we, free_re;
    logic [AW-1:0]        free_wa, free_ra, free_rd;

    logic                 rem_start, rem_done;
    logic [CW-1:0]        rem_value;

    logic                 out_free;
    logic                 out_load;
    logic [cring_pkg::TAG_OUT_W-1:0] out_tag;
    logic [cring_pkg::STATUS_W-1:0]  out_status;
    logic [CW-1:0]        pop_pos, push_pos;
    logic [AW-1:0]        new_slot, step_slot;
    logic [TAG_WIDE-1:0]  tag_in_wide, tag_rd_wide;
    logic [CNT_WIDE-1:0]  cnt_wide;

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign pop_pos  = CAP_C - count_reg - 1'b1;
    assign push_pos = CAP_C - count_reg;
    assign new_slot = fresh_reg ? count_reg[AW-1:0] : free_rd;
    assign step_slot = fwd_reg ? next_rd : prev_rd;
    assign tag_in_wide = TAG_WIDE'(s_data.tag_in);
    assign tag_rd_wide = TAG_WIDE'(tag_rd);

    always_comb begin
        state_next  = state_reg;
        cursor_next = cursor_reg;
        count_next  = count_reg;
        hw_next     = hw_reg;
        tag_next    = tag_reg;
        fresh_next  = fresh_reg;
        slot_next   = slot_reg;
        before_next = before_reg;
        fwd_next    = fwd_reg;
        left_next   = left_reg;
        status_next = status_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        tag_we  = 1'b0;
        tag_wa  = slot_reg;
        tag_re  = 1'b0;
        tag_ra  = cursor_reg;
        next_we = 1'b0;
        next_wa = slot_reg;
        next_wd = slot_reg;
        next_re = 1'b0;
        next_ra = cursor_reg;
        prev_we = 1'b0;
        prev_wa = slot_reg;
        prev_wd = slot_reg;
        prev_re = 1'b0;
        prev_ra = cursor_reg;
        free_we = 1'b0;
        free_wa = push_pos[AW-1:0];
        free_re = 1'b0;
        free_ra = pop_pos[AW-1:0];
        rem_start  = 1'b0;
        out_load   = 1'b0;
        out_tag    = '0;
        out_status = cring_pkg::STATUS_OK;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    status_next = cring_pkg::STATUS_OK;
                    case (s_data.kind)
                        cring_pkg::KIND_INSERT: begin
                            if (count_reg == CAP_C) begin
                                status_next = cring_pkg::STATUS_FULL;
                                state_next  = ST_RESULT;
                            end else begin
                                free_re    = 1'b1;
                                prev_re    = 1'b1;
                                tag_next   = tag_in_wide[TAG_BITS-1:0];
                                fresh_next = (count_reg == hw_reg);
                                state_next = ST_INS_LINK;
                            end
                        end
                        cring_pkg::KIND_REMOVE: begin
                            if (count_reg == '0) begin
                                status_next = cring_pkg::STATUS_EMPTY;
                                state_next  = ST_RESULT;
                            end else begin
                                tag_re     = 1'b1;
                                next_re    = 1'b1;
                                prev_re    = 1'b1;
                                state_next = ST_REM_FIN;
                            end
                        end
                        cring_pkg::KIND_ROLL: begin
                            fwd_next = s_data.forward;
                            if (count_reg == '0) begin
                                state_next = ST_RESULT;
                            end else begin
                                rem_start  = 1'b1;
                                state_next = ST_ROLL_MOD;
                            end
                        end
                        default: begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_INS_LINK: begin
                slot_next   = new_slot;
                before_next = prev_rd;
                tag_we      = 1'b1;
                tag_wa      = new_slot;
                next_we     = 1'b1;
                prev_we     = 1'b1;
                if (count_reg == '0) begin
                    next_wa = new_slot;
                    next_wd = new_slot;
                    prev_wa = new_slot;
                    prev_wd = new_slot;
                end else begin
                    prev_wa = cursor_reg;
                    prev_wd = new_slot;
                    next_wa = prev_rd;
                    next_wd = new_slot;
                end
                state_next = ST_INS_FIN;
            end
            ST_INS_FIN: begin
                if (out_free) begin
                    if (count_reg != '0) begin
                        next_we = 1'b1;
                        next_wa = slot_reg;
                        next_wd = cursor_reg;
                        prev_we = 1'b1;
                        prev_wa = slot_reg;
                        prev_wd = before_reg;
                    end
                    cursor_next = slot_reg;
                    count_next  = count_reg + 1'b1;
                    if (fresh_reg) begin
                        hw_next = count_reg + 1'b1;
                    end
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_REM_FIN: begin
                if (out_free) begin
                    if (count_reg > CW'(1)) begin
                        prev_we     = 1'b1;
                        prev_wa     = next_rd;
                        prev_wd     = prev_rd;
                        next_we     = 1'b1;
                        next_wa     = prev_rd;
                        next_wd     = next_rd;
                        cursor_next = next_rd;
                    end
                    free_we    = 1'b1;
                    count_next = count_reg - 1'b1;
                    out_load   = 1'b1;
                    out_tag    = tag_rd_wide[cring_pkg::TAG_OUT_W-1:0];
                    state_next = ST_IDLE;
                end
            end
            ST_ROLL_MOD: begin
                if (rem_done) begin
                    if (rem_value == '0) begin
                        state_next = ST_RESULT;
                    end else begin
                        next_re    = 1'b1;
                        prev_re    = 1'b1;
                        left_next  = rem_value;
                        state_next = ST_ROLL_WALK;
                    end
                end
            end
            ST_ROLL_WALK: begin
                cursor_next = step_slot;
                left_next   = left_reg - 1'b1;
                if (left_reg == CW'(1)) begin
                    state_next = ST_RESULT;
                end else begin
                    next_re = 1'b1;
                    next_ra = step_slot;
                    prev_re = 1'b1;
                    prev_ra = step_slot;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = status_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        cnt_wide = CNT_WIDE'(count_next);
        if (out_load) begin
            m_valid_next        = 1'b1;
            m_data_next.tag_out = out_tag;
            m_data_next.status  = out_status;
            m_data_next.count   = cnt_wide[cring_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cursor_reg  <= '0;
            count_reg   <= '0;
            hw_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cursor_reg  <= cursor_next;
            count_reg   <= count_next;
            hw_reg      <= hw_next;
            m_valid_reg <= m_valid_next;
        end
        tag_reg    <= tag_next;
        fresh_reg  <= fresh_next;
        slot_reg   <= slot_next;
        before_reg <= before_next;
        fwd_reg    <= fwd_next;
        left_reg   <= left_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    cring_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (CAPACITY)
    ) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (tag_we),
        .wr_addr (tag_wa),
        .wr_data (tag_reg),
        .rd_en   (tag_re),
        .rd_addr (tag_ra),
        .rd_data (tag_rd)
    );

    cring_ram #(
        .WIDTH (AW),
        .DEPTH (CAPACITY)
    ) u_next_ram (
        .aclk    (aclk),
        .wr_en   (next_we),
        .wr_addr (next_wa),
        .wr_data (next_wd),
        .rd_en   (next_re),
        .rd_addr (next_ra),
        .rd_data (next_rd)
    );

    cring_ram #(
        .WIDTH (AW),
        .DEPTH (CAPACITY)
    ) u_prev_ram (
        .aclk    (aclk),
        .wr_en   (prev_we),
        .wr_addr (prev_wa),
        .wr_data (prev_wd),
        .rd_en   (prev_re),
        .rd_addr (prev_ra),
        .rd_data (prev_rd)
    );

    cring_ram #(
        .WIDTH (AW),
        .DEPTH (CAPACITY)
    ) u_free_ram (
        .aclk    (aclk),
        .wr_en   (free_we),
        .wr_addr (free_wa),
        .wr_data (cursor_reg),
        .rd_en   (free_re),
        .rd_addr (free_ra),
        .rd_data (free_rd)
    );

    cring_rem #(
        .DIV_W (CW)
    ) u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (s_data.steps),
        .divisor   (count_reg),
        .done      (rem_done),
        .remainder (rem_value)
    );

endmodule

[rtl/cring_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module cring_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/cring_rem.sv]
// Iterative restoring remainder unit that reduces a roll distance modulo the entry count.
module cring_rem #(
    parameter int DIV_W = 7
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [cring_pkg::STEPS_W-1:0] dividend,
    input  logic [DIV_W-1:0]             divisor,
    output logic                         done,
    output logic [DIV_W-1:0]             remainder
);

    localparam int CNT_W = $clog2(cring_pkg::STEPS_W);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [cring_pkg::STEPS_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0]              dsr_reg, dsr_next;
    logic [DIV_W-1:0]              rem_reg, rem_next;
    logic [DIV_W:0]                shifted;
    logic [DIV_W:0]                trial;

    assign shifted = {rem_reg, dvd_reg[cring_pkg::STEPS_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(cring_pkg::STEPS_W - 1);
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = trial[DIV_W] ? shifted[DIV_W-1:0] : trial[DIV_W-1:0];
            dvd_next = {dvd_reg[cring_pkg::STEPS_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[tb/ring_checker.sv]
// Ring checker: predicts each command's result from its own model of the ring and compares.
module ring_checker
    import cring_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_data,
    output int unsigned failures
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS  = CAPACITY_DEF;
    localparam int SLOT_W = $clog2(SLOTS);

    logic [TAG_OUT_W-1:0] tag_mem    [SLOTS];
    logic [SLOT_W-1:0]    next_slot  [SLOTS];
    logic [SLOT_W-1:0]    prev_slot  [SLOTS];
    logic [SLOT_W-1:0]    free_slots [SLOTS];
    logic [SLOT_W-1:0]    cursor_slot;
    int unsigned          free_depth;
    int unsigned          live_entries;
    int unsigned          mismatches;
    int unsigned          outstanding;
    out_item_t            awaited_results [$];

    assign failures = mismatches + outstanding;

    function automatic out_item_t apply_command(input in_item_t cmd);
        out_item_t         res;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] nx;
        logic [SLOT_W-1:0] pv;
        int unsigned       moves;
        res = '0;
        res.status = STATUS_OK;
        case (cmd.kind)
            KIND_INSERT: begin
                if (live_entries >= SLOTS) begin
                    res.status = STATUS_FULL;
                end else begin
                    free_depth--;
                    slot = free_slots[SLOT_W'(free_depth)];
                    tag_mem[slot] = cmd.tag_in;
                    if (live_entries == 0) begin
                        next_slot[slot] = slot;
                        prev_slot[slot] = slot;
                    end else begin
                        pv = prev_slot[cursor_slot];
                        next_slot[slot] = cursor_slot;
                        prev_slot[slot] = pv;
                        prev_slot[cursor_slot] = slot;
                        next_slot[pv] = slot;
                    end
                    cursor_slot = slot;
                    live_entries++;
                end
            end
            KIND_REMOVE: begin
                if (live_entries == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    slot = cursor_slot;
                    res.tag_out = tag_mem[slot];
                    nx = next_slot[slot];
                    pv = prev_slot[slot];
                    if (live_entries > 1) begin
                        prev_slot[nx] = pv;
                        next_slot[pv] = nx;
                        cursor_slot = nx;
                    end
                    if (free_depth < SLOTS) begin
                        free_slots[SLOT_W'(free_depth)] = slot;
                        free_depth++;
                    end
                    live_entries--;
                end
            end
            KIND_ROLL: begin
                if (live_entries != 0) begin
                    moves = cmd.steps % live_entries;
                    for (int unsigned i = 0; i < moves; i++) begin
                        cursor_slot = cmd.forward ? next_slot[cursor_slot]
                                                  : prev_slot[cursor_slot];
                    end
                end
            end
            default: begin
            end
        endcase
        res.count = live_entries[COUNT_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                free_slots[SLOT_W'(i)] = SLOT_W'(SLOTS - 1 - i);
            end
            free_depth   = SLOTS;
            cursor_slot  = '0;
            live_entries = 0;
            mismatches   = 0;
            outstanding  = 0;
            awaited_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("Result %h arrived with no command waiting.", m_data);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    outstanding--;
                    if (m_data.tag_out !== want.tag_out) begin
                        $error("tag_out: expected %h, actual %h", want.tag_out, m_data.tag_out);
                        mismatches++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_data.status);
                        mismatches++;
                    end
                    if (m_data.count !== want.count) begin
                        $error("count: expected %0d, actual %0d", want.count, m_data.count);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                awaited_results.push_back(apply_command(s_data));
                outstanding++;
            end
        end
    end

endmodule

[tb/tb.sv]
// Testbench top: clock, reset, command stimulus, result flow control and the final verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cring_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 100;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    int unsigned failures;
    int unsigned sent = 0;
    int unsigned got  = 0;
    bit          calm = 1'b0;
    bit          hold_long = 1'b0;
    bit          hold_taken = 1'b0;

    circular_ring_list_engine dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    ring_checker watch (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .failures (failures)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got <= got + 1;
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_long && !hold_taken) begin
                hold_taken = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic in_item_t mk(input logic [KIND_W-1:0] kind, input logic [31:0] tag,
                                    input logic fwd, input logic [15:0] steps);
        in_item_t cmd;
        cmd.kind    = kind;
        cmd.tag_in  = tag;
        cmd.forward = fwd;
        cmd.steps   = steps;
        return cmd;
    endfunction

    function automatic in_item_t rand_cmd(input logic [KIND_W-1:0] kind);
        in_item_t    cmd;
        int unsigned pick;
        cmd.kind    = kind;
        cmd.forward = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 19);
        cmd.tag_in = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
            cmd.steps = 16'($urandom_range(0, 70));
        end else if (pick < 18) begin
            cmd.steps = 16'($urandom);
        end else begin
            cmd.steps = (pick == 18) ? 16'h0 : 16'hFFFF;
        end
        return cmd;
    endfunction

    task automatic push_cmd(input in_item_t cmd);
        int unsigned gap;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= cmd;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (got != sent);
    endtask

    task automatic run_phase(input int n, input int insert_pct, input int remove_pct);
        int unsigned r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < insert_pct) begin
                push_cmd(rand_cmd(KIND_INSERT));
            end else if (r < insert_pct + remove_pct) begin
                push_cmd(rand_cmd(KIND_REMOVE));
            end else if (r < 97) begin
                push_cmd(rand_cmd(KIND_ROLL));
            end else begin
                push_cmd(rand_cmd(KIND_UNUSED));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Commands on an empty ring, then a small ring walked in both directions and emptied again.
        push_cmd(mk(KIND_REMOVE, 32'h0, 1'b0, 16'h0));
        push_cmd(mk(KIND_ROLL, 32'h0, 1'b1, 16'd5));
        push_cmd(mk(KIND_UNUSED, 32'hFFFF_FFFF, 1'b1, 16'hFFFF));
        push_cmd(mk(KIND_INSERT, 32'h0, 1'b0, 16'h0));
        push_cmd(mk(KIND_INSERT, 32'hFFFF_FFFF, 1'b0, 16'h0));
        push_cmd(mk(KIND_INSERT, 32'h1234_5678, 1'b1, 16'h0));
        push_cmd(mk(KIND_INSERT, 32'hA5A5_A5A5, 1'b0, 16'hFFFF));
        push_cmd(mk(KIND_ROLL, 32'h0, 1'b1, 16'd0));
        push_cmd(mk(KIND_ROLL, 32'h0, 1'b1, 16'hFFFF));
        push_cmd(mk(KIND_ROLL, 32'h0, 1'b0, 16'hFFFF));
        push_cmd(mk(KIND_ROLL, 32'h0, 1'b1, 16'd1));
        push_cmd(mk(KIND_ROLL, 32'h0, 1'b0, 16'd3));
        push_cmd(mk(KIND_ROLL, 32'h0, 1'b1, 16'd4));
        push_cmd(mk(KIND_UNUSED, 32'h0, 1'b0, 16'h0));
        push_cmd(mk(KIND_REMOVE, 32'h0, 1'b0, 16'h0));
        push_cmd(mk(KIND_REMOVE, 32'h0, 1'b0, 16'h0));
        push_cmd(mk(KIND_REMOVE, 32'h0, 1'b0, 16'h0));
        push_cmd(mk(KIND_REMOVE, 32'h0, 1'b0, 16'h0));
        push_cmd(mk(KIND_REMOVE, 32'hFFFF_FFFF, 1'b1, 16'hFFFF));
        push_cmd(mk(KIND_ROLL, 32'h0, 1'b0, 16'd7));
        push_cmd(mk(KIND_INSERT, 32'h8000_0001, 1'b0, 16'h0));
        push_cmd(mk(KIND_REMOVE, 32'h0, 1'b0, 16'h0));
        drain();

        hold_long = 1'b1;
        run_phase(100, 75, 10);
        drain();
        run_phase(80, 40, 40);
        run_phase(100, 10, 75);
        drain();
        run_phase(100, 75, 10);
        run_phase(60, 40, 40);
        calm = 1'b1;
        run_phase(100, 10, 75);

        s_valid <= 1'b0;
        do @(posedge aclk); while (got != sent);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/cring_pkg.sv
rtl/cring_ram.sv
rtl/cring_rem.sv
rtl/circular_ring_list_engine.sv
tb/ring_checker.sv
tb/tb.sv
